// File: src/qbf_pkg.sv
package qbf_pkg;

  localparam int IndexBits = 16;

  // shared shift-add multiplier: A operand, left-aligned B operand, product
  localparam int MulAW   = 86;
  localparam int MulBW   = 64;
  localparam int MulPW   = 118;
  localparam int MulCntW = 7;

  localparam logic [MulCntW-1:0] MulSteps32 = MulCntW'(32);
  localparam logic [MulCntW-1:0] MulSteps34 = MulCntW'(34);

  localparam logic [5:0] SqrtSteps = 6'd34;
  localparam logic [5:0] DivSteps  = 6'd47;

  localparam logic [46:0] Max47 = '1;
  localparam logic [62:0] Max63 = '1;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
    logic [30:0]        rest_length;
    logic [31:0]        stiffness;
    logic [15:0]        index_a;
    logic [15:0]        index_b;
    logic               last_bond;
  } in_t;

  typedef struct packed {
    logic [15:0]        out_index_a;
    logic [15:0]        out_index_b;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic [46:0]        bond_energy;
    logic [62:0]        energy_total;
    logic               last;
  } out_t;

  typedef struct packed {
    logic               start;
    logic [MulCntW-1:0] steps;
  } mul_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MUL_W,
    S_SQRT,
    S_FORCE,
    S_DIV,
    S_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_SQ,
    OP_M2,
    OP_M3,
    OP_M4,
    OP_EN,
    OP_KM3,
    OP_F
  } op_e;

endpackage

// File: src/qbf_mul.sv
module qbf_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  qbf_pkg::mul_cmd_t          cmd_i,
  input  logic [qbf_pkg::MulAW-1:0]  a_i,
  input  logic [qbf_pkg::MulBW-1:0]  b_i,
  output logic                       done_o,
  output logic [qbf_pkg::MulPW-1:0]  prod_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [qbf_pkg::MulCntW-1:0]   cnt_q;
  logic [qbf_pkg::MulAW-1:0]     a_q;
  logic [qbf_pkg::MulBW-1:0]     b_q;
  logic [qbf_pkg::MulPW-1:0]     acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - qbf_pkg::MulCntW'(1);
        if (cnt_q == qbf_pkg::MulCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // MSB-first: one multiplier bit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[qbf_pkg::MulPW-2:0], 1'b0}
             + (b_q[qbf_pkg::MulBW-1] ? qbf_pkg::MulPW'(a_q) : '0);
      b_q   <= {b_q[qbf_pkg::MulBW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: src/quartic_bond_force.sv
// Quartic bond force unit.
// Input channel (in_valid_i / in_stall_o / in_data_i): one bond per word, taken
// when valid is high and stall is low. Output channel (out_valid_o /
// out_stall_i / out_data_o): one result word per bond, in order.
// From acceptance until its result is loaded into the output register, a bond
// goes through eleven products on one bit-serial multiplier, a square root and,
// per force component, a setup state, a product and a divide.
// A saturated force skips its divide, coincident particles skip all three.
// in_stall_o stays high from acceptance until the result is moved into the
// output register, so only one bond is in progress at a time; a new bond
// is taken while that result still waits on a stalled receiver. A stalled
// result holds unchanged; if the previous result is still stalled when the
// next one is done, the unit waits before loading it.
// The running energy sum includes every bond since the last word flagged
// last_bond and clears after that word. Reset (rst_ni low) clears the sum,
// drops out_valid_o and returns to idle; there is no clearing pass.
module quartic_bond_force #(
  parameter int INDEX_BITS = qbf_pkg::IndexBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  qbf_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output qbf_pkg::out_t out_data_o
);

  localparam logic [15:0] IdxMask =
    (INDEX_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << INDEX_BITS) - 32'd1);

  qbf_pkg::state_e state_q, state_d;
  qbf_pkg::op_e    op_q, op_d;
  logic [5:0]      cnt_q;
  logic [1:0]      c_q;

  qbf_pkg::in_t    in_q;
  logic [31:0]     ad_q [3];
  logic [2:0]      dneg_q;
  logic [67:0]     src_q;
  logic [48:0]     rem_q;
  logic [33:0]     root_q;
  logic [46:0]     quo_q;
  logic [33:0]     r_q;
  logic [43:0]     m2_q;
  logic [53:0]     m3_q;
  logic [63:0]     m4_q;
  logic [85:0]     km3_q;
  logic [46:0]     energy_q;
  logic [62:0]     total_q;
  logic [47:0]     force_q [3];
  logic [62:0]     acc_q;
  qbf_pkg::out_t   out_q;
  logic            out_valid_q;

  logic [31:0]     pa [3];
  logic [31:0]     pb [3];
  logic [32:0]     dw [3];
  logic [31:0]     adw [3];

  qbf_pkg::mul_cmd_t           mul_cmd;
  logic [qbf_pkg::MulAW-1:0]   mul_a;
  logic [qbf_pkg::MulBW-1:0]   mul_b;
  logic                        mul_done;
  logic [qbf_pkg::MulPW-1:0]   mul_prod;

  logic [34:0]     drw;
  logic [33:0]     m_w;
  logic [37:0]     sq_t;
  logic [37:0]     sq_trial;
  logic            sq_ge;
  logic [48:0]     dv_t;
  logic [48:0]     dv_d;
  logic            dv_ge;
  logic            f_sat;
  logic            f_neg;
  logic            last_c;
  logic            can_load;
  logic [46:0]     en_w;
  logic [63:0]     tot_w;
  logic [46:0]     q_fin;

  assign pa[0] = in_data_i.pos_a_x;
  assign pa[1] = in_data_i.pos_a_y;
  assign pa[2] = in_data_i.pos_a_z;
  assign pb[0] = in_data_i.pos_b_x;
  assign pb[1] = in_data_i.pos_b_y;
  assign pb[2] = in_data_i.pos_b_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dw[i]  = {pa[i][31], pa[i]} - {pb[i][31], pb[i]};
      adw[i] = dw[i][32] ? 32'(-dw[i]) : dw[i][31:0];
    end
  end

  assign drw = {1'b0, r_q} - {4'b0, in_q.rest_length};
  assign m_w = drw[34] ? 34'(-drw) : drw[33:0];

  // square root: two radicand bits per cycle
  assign sq_t     = {rem_q[35:0], src_q[67:66]};
  assign sq_trial = {2'b0, root_q, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;

  // restoring divide by r * 2^14: one quotient bit per cycle
  assign dv_t  = {rem_q[47:0], src_q[67]};
  assign dv_d  = {1'b0, r_q, 14'b0};
  assign dv_ge = dv_t >= dv_d;
  assign q_fin = {quo_q[45:0], dv_ge};

  // quotient reaches 2^47 exactly when the dividend reaches r * 2^61
  assign f_sat  = mul_prod >= {23'b0, r_q, 61'b0};
  assign f_neg  = dneg_q[c_q] != drw[34];
  assign last_c = c_q == 2'd2;

  assign en_w  = (|mul_prod[95:63]) ? qbf_pkg::Max47 : mul_prod[62:16];
  assign tot_w = {1'b0, acc_q} + {17'b0, en_w};

  assign can_load = !out_valid_q || !out_stall_i;

  function automatic logic [47:0] signed_force(logic [46:0] mag, logic neg);
    logic [47:0] v;
    v = {1'b0, mag};
    return neg ? 48'(-v) : v;
  endfunction

  always_comb begin
    mul_cmd.start = state_q == qbf_pkg::S_MUL;
    mul_cmd.steps = qbf_pkg::MulSteps32;
    mul_a         = '0;
    mul_b         = '0;
    unique case (op_q)
      qbf_pkg::OP_SQ: begin
        mul_a = qbf_pkg::MulAW'(ad_q[c_q]);
        mul_b = {ad_q[c_q], 32'b0};
      end
      qbf_pkg::OP_M2: begin
        mul_a         = qbf_pkg::MulAW'(m_w);
        mul_b         = {m_w, 30'b0};
        mul_cmd.steps = qbf_pkg::MulSteps34;
      end
      qbf_pkg::OP_M3: begin
        mul_a         = qbf_pkg::MulAW'(m2_q);
        mul_b         = {m_w, 30'b0};
        mul_cmd.steps = qbf_pkg::MulSteps34;
      end
      qbf_pkg::OP_M4: begin
        mul_a         = qbf_pkg::MulAW'(m3_q);
        mul_b         = {m_w, 30'b0};
        mul_cmd.steps = qbf_pkg::MulSteps34;
      end
      qbf_pkg::OP_EN: begin
        mul_a = qbf_pkg::MulAW'(m4_q);
        mul_b = {in_q.stiffness, 32'b0};
      end
      qbf_pkg::OP_KM3: begin
        mul_a = qbf_pkg::MulAW'(m3_q);
        mul_b = {in_q.stiffness, 32'b0};
      end
      qbf_pkg::OP_F: begin
        mul_a = km3_q;
        mul_b = {ad_q[c_q], 32'b0};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  qbf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      qbf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = qbf_pkg::S_MUL;
          op_d    = qbf_pkg::OP_SQ;
        end
      end
      qbf_pkg::S_MUL: begin
        state_d = qbf_pkg::S_MUL_W;
      end
      qbf_pkg::S_MUL_W: begin
        if (mul_done) begin
          unique case (op_q)
            qbf_pkg::OP_SQ:  state_d = last_c ? qbf_pkg::S_SQRT : qbf_pkg::S_MUL;
            qbf_pkg::OP_M2: begin
              state_d = qbf_pkg::S_MUL;
              op_d    = qbf_pkg::OP_M3;
            end
            qbf_pkg::OP_M3: begin
              state_d = qbf_pkg::S_MUL;
              op_d    = qbf_pkg::OP_M4;
            end
            qbf_pkg::OP_M4: begin
              state_d = qbf_pkg::S_MUL;
              op_d    = qbf_pkg::OP_EN;
            end
            qbf_pkg::OP_EN: begin
              state_d = qbf_pkg::S_MUL;
              op_d    = qbf_pkg::OP_KM3;
            end
            qbf_pkg::OP_KM3: state_d = qbf_pkg::S_FORCE;
            qbf_pkg::OP_F: begin
              if (!f_sat) state_d = qbf_pkg::S_DIV;
              else        state_d = last_c ? qbf_pkg::S_OUT : qbf_pkg::S_FORCE;
            end
            default: state_d = qbf_pkg::S_IDLE;
          endcase
        end
      end
      qbf_pkg::S_SQRT: begin
        if (cnt_q == 6'd1) begin
          state_d = qbf_pkg::S_MUL;
          op_d    = qbf_pkg::OP_M2;
        end
      end
      qbf_pkg::S_FORCE: begin
        // coincident particles: no force, skip the divide
        if (r_q == '0) begin
          state_d = last_c ? qbf_pkg::S_OUT : qbf_pkg::S_FORCE;
        end else begin
          state_d = qbf_pkg::S_MUL;
          op_d    = qbf_pkg::OP_F;
        end
      end
      qbf_pkg::S_DIV: begin
        if (cnt_q == 6'd1) state_d = last_c ? qbf_pkg::S_OUT : qbf_pkg::S_FORCE;
      end
      qbf_pkg::S_OUT: begin
        if (can_load) state_d = qbf_pkg::S_IDLE;
      end
      default: state_d = qbf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qbf_pkg::S_IDLE;
      op_q        <= qbf_pkg::OP_SQ;
      cnt_q       <= '0;
      c_q         <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      case (state_q)
        qbf_pkg::S_IDLE: c_q <= '0;
        qbf_pkg::S_MUL_W: begin
          if (mul_done) begin
            if (op_q == qbf_pkg::OP_SQ) begin
              c_q   <= last_c ? 2'd0 : c_q + 2'd1;
              cnt_q <= qbf_pkg::SqrtSteps;
            end else if (op_q == qbf_pkg::OP_KM3) begin
              c_q <= '0;
            end else if (op_q == qbf_pkg::OP_F) begin
              cnt_q <= qbf_pkg::DivSteps;
              if (f_sat) c_q <= c_q + 2'd1;
            end
          end
        end
        qbf_pkg::S_SQRT: cnt_q <= cnt_q - 6'd1;
        qbf_pkg::S_FORCE: begin
          if (r_q == '0) c_q <= c_q + 2'd1;
        end
        qbf_pkg::S_DIV: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) c_q <= c_q + 2'd1;
        end
        default: c_q <= c_q;
      endcase
      if (state_q == qbf_pkg::S_OUT && can_load) begin
        out_valid_q <= 1'b1;
        acc_q       <= in_q.last_bond ? '0 : total_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      qbf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          in_q  <= in_data_i;
          src_q <= '0;
          for (int i = 0; i < 3; i++) begin
            ad_q[i]   <= adw[i];
            dneg_q[i] <= dw[i][32];
          end
        end
      end
      qbf_pkg::S_MUL_W: begin
        if (mul_done) begin
          unique case (op_q)
            qbf_pkg::OP_SQ: begin
              src_q  <= src_q + mul_prod[67:0];
              rem_q  <= '0;
              root_q <= '0;
            end
            qbf_pkg::OP_M2:  m2_q  <= mul_prod[67:24];
            qbf_pkg::OP_M3:  m3_q  <= mul_prod[77:24];
            qbf_pkg::OP_M4:  m4_q  <= mul_prod[87:24];
            qbf_pkg::OP_EN: begin
              energy_q <= en_w;
              total_q  <= tot_w[63] ? qbf_pkg::Max63 : tot_w[62:0];
            end
            qbf_pkg::OP_KM3: km3_q <= mul_prod[85:0];
            qbf_pkg::OP_F: begin
              if (f_sat) begin
                force_q[c_q] <= signed_force(qbf_pkg::Max47, f_neg);
              end else begin
                rem_q <= {1'b0, mul_prod[94:47]};
                src_q <= {mul_prod[46:0], 21'b0};
                quo_q <= '0;
              end
            end
            default: src_q <= src_q;
          endcase
        end
      end
      qbf_pkg::S_SQRT: begin
        rem_q  <= {11'b0, sq_ge ? 38'(sq_t - sq_trial) : sq_t};
        root_q <= {root_q[32:0], sq_ge};
        src_q  <= {src_q[65:0], 2'b0};
        if (cnt_q == 6'd1) r_q <= {root_q[32:0], sq_ge};
      end
      qbf_pkg::S_FORCE: begin
        if (r_q == '0) force_q[c_q] <= '0;
      end
      qbf_pkg::S_DIV: begin
        rem_q <= dv_ge ? dv_t - dv_d : dv_t;
        src_q <= {src_q[66:0], 1'b0};
        quo_q <= q_fin;
        if (cnt_q == 6'd1) force_q[c_q] <= signed_force(q_fin, f_neg);
      end
      qbf_pkg::S_OUT: begin
        if (can_load) begin
          out_q.out_index_a  <= in_q.index_a & IdxMask;
          out_q.out_index_b  <= in_q.index_b & IdxMask;
          out_q.force_x      <= force_q[0];
          out_q.force_y      <= force_q[1];
          out_q.force_z      <= force_q[2];
          out_q.bond_energy  <= energy_q;
          out_q.energy_total <= total_q;
          out_q.last         <= in_q.last_bond;
        end
      end
      default: src_q <= src_q;
    endcase
  end

  assign in_stall_o  = state_q != qbf_pkg::S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/qbf_checker.sv
module qbf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input qbf_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input qbf_pkg::out_t out_data_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // one bond in flight: after taking a word the input side stalls
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a bond is in progress");

  // a result only appears at the end of a bond's computation
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a bond in progress");

  a_energy_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {16'b0, out_data_o.bond_energy} <= out_data_o.energy_total)
    else $error("running energy below bond energy");

endmodule

bind quartic_bond_force qbf_checker u_qbf_checker (.*);
